### src/ipvps_pkg.sv
`timescale 1ns / 1ps

package ipvps_pkg;

    localparam int CHAR_W   = 8;
    localparam int VALUE_W  = 17;
    localparam int INDEX_W  = 3;
    localparam int COUNT_W  = 2;
    localparam int ADDR_W   = 32;
    localparam int PORT_W   = 16;
    localparam int OCTETS_W = 24;

    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    localparam logic [VALUE_W-1:0] OCTET_MAX = 17'd255;
    localparam logic [VALUE_W-1:0] PORT_MAX  = 17'd65535;
    localparam logic [VALUE_W-1:0] VALUE_SAT = 17'd131071;

    localparam logic [INDEX_W-1:0] FIELD_OCTET_LAST = 3'd3;
    localparam logic [INDEX_W-1:0] FIELD_PORT       = 3'd4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 2'd3;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last_char;
    } in_item_t;

    typedef struct packed {
        logic              valid_res;
        logic [ADDR_W-1:0] ip_address;
        logic [PORT_W-1:0] port;
    } out_item_t;

endpackage

### src/ipvps_core.sv
`timescale 1ns / 1ps

module ipvps_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  ipvps_pkg::in_item_t item,
    output ipvps_pkg::out_item_t result
);
    import ipvps_pkg::*;

    logic [INDEX_W-1:0]  field_index_reg,  field_index_next;
    logic [VALUE_W-1:0]  field_value_reg,  field_value_next;
    logic [COUNT_W-1:0]  digit_count_reg,  digit_count_next;
    logic                leading_zero_reg, leading_zero_next;
    logic                error_seen_reg,   error_seen_next;
    logic [OCTETS_W-1:0] octets_done_reg,  octets_done_next;
    logic [7:0]          octet_four_reg,   octet_four_next;

    logic                is_digit;
    logic [3:0]          digit;
    logic [VALUE_W+3:0]  mul10;
    logic                octet_ok;
    logic                port_ok;

    assign is_digit = (item.ch >= CH_ZERO) && (item.ch <= CH_NINE);
    assign digit    = item.ch[3:0];
    // v*10 + d as (v<<3) + (v<<1) + d
    assign mul10    = {1'b0, field_value_reg, 3'b000}
                    + {3'b000, field_value_reg, 1'b0}
                    + {{(VALUE_W){1'b0}}, digit};
    assign octet_ok = (digit_count_reg != '0) && (field_value_reg <= OCTET_MAX);

    always_comb begin
        field_index_next  = field_index_reg;
        field_value_next  = field_value_reg;
        digit_count_next  = digit_count_reg;
        leading_zero_next = leading_zero_reg;
        error_seen_next   = error_seen_reg;
        octets_done_next  = octets_done_reg;
        octet_four_next   = octet_four_reg;

        if (is_digit) begin
            if ((digit_count_reg != '0) && leading_zero_reg) begin
                error_seen_next = 1'b1;
            end
            if ((digit_count_reg == '0) && (digit == 4'd0)) begin
                leading_zero_next = 1'b1;
            end
            if (mul10 > {4'b0000, VALUE_SAT}) begin
                field_value_next = VALUE_SAT;
            end else begin
                field_value_next = mul10[VALUE_W-1:0];
            end
            if (digit_count_reg != COUNT_MAX) begin
                digit_count_next = digit_count_reg + 1'b1;
            end
        end else if (item.ch == CH_DOT) begin
            if ((field_index_reg < FIELD_OCTET_LAST) && octet_ok) begin
                octets_done_next  = {octets_done_reg[OCTETS_W-9:0], field_value_reg[7:0]};
                field_index_next  = field_index_reg + 1'b1;
                field_value_next  = '0;
                digit_count_next  = '0;
                leading_zero_next = 1'b0;
            end else begin
                error_seen_next = 1'b1;
            end
        end else if (item.ch == CH_COLON) begin
            if ((field_index_reg == FIELD_OCTET_LAST) && octet_ok) begin
                octet_four_next   = field_value_reg[7:0];
                field_index_next  = FIELD_PORT;
                field_value_next  = '0;
                digit_count_next  = '0;
                leading_zero_next = 1'b0;
            end else begin
                error_seen_next = 1'b1;
            end
        end else begin
            error_seen_next = 1'b1;
        end
    end

    assign port_ok = !error_seen_next && (field_index_next == FIELD_PORT)
                   && (digit_count_next != '0) && (field_value_next <= PORT_MAX);

    always_comb begin
        result.valid_res  = port_ok;
        result.ip_address = port_ok ? {octets_done_next, octet_four_next} : '0;
        result.port       = port_ok ? field_value_next[PORT_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_index_reg  <= '0;
            field_value_reg  <= '0;
            digit_count_reg  <= '0;
            leading_zero_reg <= 1'b0;
            error_seen_reg   <= 1'b0;
        end else if (step_en) begin
            if (item.last_char) begin
                // string done: parse state back to start
                field_index_reg  <= '0;
                field_value_reg  <= '0;
                digit_count_reg  <= '0;
                leading_zero_reg <= 1'b0;
                error_seen_reg   <= 1'b0;
            end else begin
                field_index_reg  <= field_index_next;
                field_value_reg  <= field_value_next;
                digit_count_reg  <= digit_count_next;
                leading_zero_reg <= leading_zero_next;
                error_seen_reg   <= error_seen_next;
            end
        end
    end

    // fully rewritten by three dots and a colon before they can be reported
    always_ff @(posedge aclk) begin
        if (step_en) begin
            octets_done_reg <= octets_done_next;
            octet_four_reg  <= octet_four_next;
        end
    end

endmodule

### src/ipv4_port_string_validator.sv
`timescale 1ns / 1ps

// Checks an "a.b.c.d:p" address string streamed one character per item, with
// last_char on the final one. One character is taken every clock cycle unless
// a last character waits for the result register; the parse update (a
// multiply-by-ten add and a range compare) is combinational between the input
// register and the state registers. Only the last character of a string yields
// a result item: m_valid rises once that character moves from the input
// register into the result register. The result register lets the next string
// start while a result still waits for m_ready; only the next last character
// stalls behind it. When valid_res is 0, ip_address and port read as zero.
module ipv4_port_string_validator (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ipvps_pkg::in_item_t  s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ipvps_pkg::out_item_t m_item
);
    import ipvps_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t result;
    logic      out_free;
    logic      advance;

    assign out_free = !out_valid_reg || m_ready;
    // an item with no result never waits on the output side
    assign advance  = in_valid_reg && (!in_item_reg.last_char || out_free);
    assign s_ready  = !in_valid_reg || advance;

    ipvps_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_item_reg.last_char) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_item_reg.last_char) begin
            out_item_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

### tb/sv/ipv4_port_parse_checker.sv
`timescale 1ns / 1ps

module ipv4_port_parse_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  ipvps_pkg::in_item_t  s_item,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  ipvps_pkg::out_item_t m_item,
    output int                   mismatches,
    output int                   outstanding,
    output int                   results_seen,
    output int                   valid_seen
);

    import ipvps_pkg::*;

    // parse state mirrored from the block
    logic [INDEX_W-1:0]  fld_idx;
    logic [VALUE_W-1:0]  fld_val;
    logic [COUNT_W-1:0]  dig_cnt;
    logic                lead_zero;
    logic                fmt_err;
    logic [OCTETS_W-1:0] octets;
    logic [7:0]          octet4;

    out_item_t addr_q[$];
    out_item_t want;

    function automatic void clear_field();
        fld_val   = '0;
        dig_cnt   = '0;
        lead_zero = 1'b0;
    endfunction

    function automatic void restart_parse();
        fld_idx = '0;
        clear_field();
        fmt_err = 1'b0;
        octets  = '0;
        octet4  = '0;
    endfunction

    function automatic bit field_fits(input logic [VALUE_W-1:0] limit);
        return dig_cnt != '0 && fld_val <= limit;
    endfunction

    function automatic void parse_char(input in_item_t it);
        int unsigned acc;
        logic [7:0]  digit;
        bit          ok;
        out_item_t   res;
        if (it.ch >= CH_ZERO && it.ch <= CH_NINE) begin
            digit = it.ch - CH_ZERO;
            if (dig_cnt != '0 && lead_zero)
                fmt_err = 1'b1;
            if (dig_cnt == '0 && digit == 8'd0)
                lead_zero = 1'b1;
            acc = fld_val * 10 + digit;
            fld_val = (acc > VALUE_SAT) ? VALUE_SAT : VALUE_W'(acc);
            if (dig_cnt < COUNT_MAX)
                dig_cnt = dig_cnt + 1'b1;
        end else if (it.ch == CH_DOT) begin
            if (fld_idx < FIELD_OCTET_LAST && field_fits(OCTET_MAX)) begin
                octets  = {octets[OCTETS_W-9:0], fld_val[7:0]};
                fld_idx = fld_idx + 1'b1;
                clear_field();
            end else begin
                fmt_err = 1'b1;
            end
        end else if (it.ch == CH_COLON) begin
            if (fld_idx == FIELD_OCTET_LAST && field_fits(OCTET_MAX)) begin
                octet4  = fld_val[7:0];
                fld_idx = FIELD_PORT;
                clear_field();
            end else begin
                fmt_err = 1'b1;
            end
        end else begin
            fmt_err = 1'b1;
        end

        if (it.last_char) begin
            ok = !fmt_err && fld_idx == FIELD_PORT && field_fits(PORT_MAX);
            res.valid_res  = ok;
            res.ip_address = ok ? {octets, octet4} : '0;
            res.port       = ok ? fld_val[PORT_W-1:0] : '0;
            addr_q.push_back(res);
            restart_parse();
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            restart_parse();
            addr_q.delete();
            mismatches   = 0;
            outstanding  = 0;
            results_seen = 0;
            valid_seen   = 0;
        end else begin
            if (s_valid && s_ready)
                parse_char(s_item);
            if (m_valid && m_ready) begin
                results_seen++;
                if (addr_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: valid_res=%0b ip_address=%h port=%0d",
                                 m_item.valid_res, m_item.ip_address, m_item.port);
                end else begin
                    want = addr_q.pop_front();
                    if (m_item.valid_res !== want.valid_res
                            || m_item.ip_address !== want.ip_address
                            || m_item.port !== want.port) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected valid_res=%0b ip_address=%h port=%0d",
                                     want.valid_res, want.ip_address, want.port);
                            $display("          got      valid_res=%0b ip_address=%h port=%0d",
                                     m_item.valid_res, m_item.ip_address, m_item.port);
                        end
                    end
                    if (want.valid_res)
                        valid_seen++;
                end
            end
            outstanding = addr_q.size();
        end
    end

endmodule

### tb/sv/tb_ipv4_port_string_validator.sv
`timescale 1ns / 1ps

module tb_ipv4_port_string_validator;

    import ipvps_pkg::*;

    localparam int TOTAL_CHARS = 1850;
    localparam int STALL_LIMIT = 2000;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    int mismatches;
    int outstanding;
    int results_seen;
    int valid_seen;

    int src_idle_pct = 12;
    int snk_idle_pct = 74;
    int chars_sent   = 0;
    int strings_sent = 0;
    int stall_cycles = 0;

    logic [7:0] str_q[$];

    always #5 aclk = ~aclk;

    ipv4_port_string_validator u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    ipv4_port_parse_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_item       (s_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item       (m_item),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .valid_seen   (valid_seen)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic void put_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            str_q.push_back(txt[i]);
    endfunction

    function automatic int unsigned pick_value(input int unsigned limit);
        case ($urandom_range(7))
            0:       return 0;
            1:       return limit;
            2:       return $urandom_range(9);
            default: return $urandom_range(limit);
        endcase
    endfunction

    // occasionally damages a field: empty, leading zero, just out of range, overlong
    function automatic void put_field(input int unsigned val, input int unsigned limit);
        int unsigned r;
        r = $urandom_range(199);
        if (r < 3)
            return;
        if (r < 6)
            str_q.push_back(CH_ZERO);
        else if (r < 9)
            val = $urandom_range(limit + 1, limit * 2 + 1);
        else if (r < 11)
            val = $urandom_range(1000000, 99999999);
        put_text($sformatf("%0d", val));
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(5))
            0:       return CH_DOT;
            1:       return CH_COLON;
            2, 3:    return CH_ZERO + 8'($urandom_range(9));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic void build_address();
        for (int k = 0; k < 4; k++) begin
            put_field(pick_value(255), 255);
            if (k < 3)
                str_q.push_back(CH_DOT);
        end
        str_q.push_back(CH_COLON);
        put_field(pick_value(65535), 65535);
    endfunction

    // mostly well-formed addresses, some with one character hit, some cut short,
    // the rest plain noise
    function automatic void build_string();
        int unsigned kind;
        int unsigned pos;
        int unsigned len;
        str_q.delete();
        kind = $urandom_range(99);
        if (kind < 85) begin
            build_address();
            if (kind >= 60 && kind < 75) begin
                pos = $urandom_range(str_q.size() - 1);
                case ($urandom_range(2))
                    0:       str_q[pos] = pick_char();
                    1:       str_q.insert(pos, pick_char());
                    default: str_q.delete(pos);
                endcase
            end else if (kind >= 75) begin
                len = $urandom_range(1, str_q.size() - 1);
                while (str_q.size() > len)
                    void'(str_q.pop_back());
            end
        end else begin
            len = $urandom_range(1, 20);
            repeat (len) str_q.push_back(pick_char());
        end
    endfunction

    task automatic send_string();
        for (int i = 0; i < str_q.size(); i++) begin
            while ($urandom_range(99) < src_idle_pct) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_item  <= '{ch: str_q[i], last_char: (i == str_q.size() - 1)};
            @(posedge aclk);
            while (!s_ready)
                @(posedge aclk);
            chars_sent++;
        end
        strings_sent++;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // largest legal values, lone separator, lone stray byte, lone digit
        str_q.delete();
        put_text("255.255.255.255:65535");
        send_string();
        str_q.delete();
        str_q.push_back(CH_COLON);
        send_string();
        str_q.delete();
        str_q.push_back(8'hFF);
        send_string();
        str_q.delete();
        put_text("7");
        send_string();

        while (chars_sent < TOTAL_CHARS) begin
            if (chars_sent >= 2 * TOTAL_CHARS / 3) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else if (chars_sent >= TOTAL_CHARS / 3) begin
                src_idle_pct = 74;
                snk_idle_pct = 12;
            end
            build_string();
            send_string();
        end
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Streamed %0d characters in %0d strings under three backpressure mixes.",
                 chars_sent, strings_sent);
        $display("Checked %0d results, %0d of them well-formed addresses.",
                 results_seen, valid_seen);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
